// ----- rtl/gwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian window convolution package
// Shared constants, register indexes and types for the convolution unit.
// ----------------------------------------------------------------------------
package gwc_pkg;

    localparam int KERNEL_MAX      = 5;
    localparam int NUM_LINES       = KERNEL_MAX - 1;
    localparam int PIXEL_W         = 8;
    localparam int LINE_W          = NUM_LINES * PIXEL_W;
    localparam int CFG_DATA_W      = 60;
    localparam int CFG_INDEX_W     = 3;
    localparam int RADIUS_W        = 2;
    localparam int DIM_W           = 12;

    localparam int DEF_MAX_WIDTH   = 2048;
    localparam int DEF_COEFF_WIDTH = 12;

    localparam logic [RADIUS_W-1:0] RESET_RADIUS = 2'd2;
    localparam logic [DIM_W-1:0]    RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0]    RESET_HEIGHT = 12'd480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_KERNEL_RADIUS = 3'd0,
        REG_IMAGE_WIDTH   = 3'd1,
        REG_IMAGE_HEIGHT  = 3'd2,
        REG_COEFF_COLUMN0 = 3'd3,
        REG_COEFF_COLUMN1 = 3'd4,
        REG_COEFF_COLUMN2 = 3'd5,
        REG_COEFF_COLUMN3 = 3'd6,
        REG_COEFF_COLUMN4 = 3'd7
    } cfg_reg_t;

    typedef logic [PIXEL_W-1:0] pixel_t;

    typedef logic [KERNEL_MAX-1:0][KERNEL_MAX-1:0][PIXEL_W-1:0] window_t;

    typedef logic [KERNEL_MAX-1:0][CFG_DATA_W-1:0] coeff_bank_t;

    typedef struct packed {
        logic valid;
        logic last_of_frame;
        logic narrow;
    } mac_req_t;

endpackage

// ----- rtl/gwc_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read synchronous memory holding the prior
// rows of each column, with a registered read.
// ----------------------------------------------------------------------------
module gwc_line_store #(
    parameter int DEPTH = gwc_pkg::DEF_MAX_WIDTH
) (
    input  logic                        clk,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [gwc_pkg::LINE_W-1:0]  rd_data,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [gwc_pkg::LINE_W-1:0]  wr_data
);

    logic [gwc_pkg::LINE_W-1:0] mem [DEPTH];
    logic [gwc_pkg::LINE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/gwc_window.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window register
// Holds the most recent columns of the neighbourhood and shifts a new column
// in from the line store and the incoming pixel.
// ----------------------------------------------------------------------------
module gwc_window (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        shift_en,
    input  logic [gwc_pkg::LINE_W-1:0]  line_word,
    input  gwc_pkg::pixel_t             pixel,
    output gwc_pkg::window_t            window
);

    gwc_pkg::window_t win_reg;
    gwc_pkg::window_t win_next;

    always_comb
    begin
        for (int i = 0; i < gwc_pkg::KERNEL_MAX; i++)
        begin
            for (int j = 0; j < gwc_pkg::KERNEL_MAX - 1; j++)
            begin
                win_next[i][j] = win_reg[i][j+1];
            end
        end
        for (int i = 0; i < gwc_pkg::NUM_LINES; i++)
        begin
            win_next[i][gwc_pkg::KERNEL_MAX-1] = line_word[i*gwc_pkg::PIXEL_W +: gwc_pkg::PIXEL_W];
        end
        win_next[gwc_pkg::NUM_LINES][gwc_pkg::KERNEL_MAX-1] = pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    assign window = win_reg;

endmodule

// ----- rtl/gwc_mac_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multiply-accumulate pipeline
// Multiplies the window by the kernel taps, sums per column, then in total,
// and rounds towards zero with saturation into the output register.
// ----------------------------------------------------------------------------
module gwc_mac_pipe #(
    parameter int COEFF_WIDTH = gwc_pkg::DEF_COEFF_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gwc_pkg::mac_req_t       req,
    output logic                    req_ready,
    input  gwc_pkg::window_t        window,
    input  gwc_pkg::coeff_bank_t    coeff,
    output logic                    out_valid,
    input  logic                    out_ready,
    output gwc_pkg::pixel_t         filtered_pixel,
    output logic                    last_of_frame
);

    localparam int KM     = gwc_pkg::KERNEL_MAX;
    localparam int PROD_W = COEFF_WIDTH + gwc_pkg::PIXEL_W + 1;
    localparam int COL_W  = PROD_W + 3;
    localparam int SUM_W  = COL_W + 3;

    logic s2_valid_reg;
    logic s2_last_reg;
    logic s2_narrow_reg;
    logic s3_valid_reg;
    logic s3_last_reg;
    logic s4_valid_reg;
    logic s4_last_reg;
    logic out_valid_reg;
    logic out_last_reg;
    gwc_pkg::pixel_t out_pixel_reg;
    gwc_pkg::pixel_t out_pixel_next;

    logic signed [PROD_W-1:0] prod_next [KM][KM];
    logic signed [PROD_W-1:0] prod_reg  [KM][KM];
    logic signed [COL_W-1:0]  col_next  [KM];
    logic signed [COL_W-1:0]  col_reg   [KM];
    logic signed [SUM_W-1:0]  total;
    logic signed [SUM_W-1:0]  shifted;

    logic ready5;
    logic ready4;
    logic ready3;
    logic ready2;

    assign ready5    = !out_valid_reg || out_ready;
    assign ready4    = !s4_valid_reg || ready5;
    assign ready3    = !s3_valid_reg || ready4;
    assign ready2    = !s2_valid_reg || ready3;
    assign req_ready = ready2;

    // In the 3x3 case the newest column and row sit at the edge of the
    // window, so the centre taps are paired with a window shifted by one.
    for (genvar gi = 0; gi < KM; gi++)
    begin : g_row
        for (genvar gj = 0; gj < KM; gj++)
        begin : g_col
            gwc_pkg::pixel_t          sel;
            logic signed [COEFF_WIDTH-1:0] tap;

            if (gi >= 1 && gi <= KM - 2 && gj >= 1 && gj <= KM - 2)
            begin : g_centre
                assign sel = s2_narrow_reg ? window[gi+1][gj+1] : window[gi][gj];
            end
            else
            begin : g_outer
                assign sel = s2_narrow_reg ? '0 : window[gi][gj];
            end

            assign tap = $signed(coeff[gj][gi*COEFF_WIDTH +: COEFF_WIDTH]);
            assign prod_next[gi][gj] = $signed({1'b0, sel}) * tap;
        end
    end

    always_comb
    begin
        for (int j = 0; j < KM; j++)
        begin
            col_next[j] = '0;
            for (int i = 0; i < KM; i++)
            begin
                col_next[j] = col_next[j] + COL_W'(prod_reg[i][j]);
            end
        end
    end

    always_comb
    begin
        total = '0;
        for (int j = 0; j < KM; j++)
        begin
            total = total + SUM_W'(col_reg[j]);
        end
        shifted = total >>> (COEFF_WIDTH - 1);
        if (total[SUM_W-1] || total == '0)
        begin
            out_pixel_next = '0;
        end
        else if (|shifted[SUM_W-1:gwc_pkg::PIXEL_W])
        begin
            out_pixel_next = '1;
        end
        else
        begin
            out_pixel_next = shifted[gwc_pkg::PIXEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready2)
            begin
                s2_valid_reg <= req.valid;
            end
            if (ready3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ready4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (ready5)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready2 && req.valid)
        begin
            s2_last_reg   <= req.last_of_frame;
            s2_narrow_reg <= req.narrow;
        end
        if (ready3 && s2_valid_reg)
        begin
            s3_last_reg <= s2_last_reg;
            prod_reg    <= prod_next;
        end
        if (ready4 && s3_valid_reg)
        begin
            s4_last_reg <= s3_last_reg;
            col_reg     <= col_next;
        end
        if (ready5 && s4_valid_reg)
        begin
            out_last_reg  <= s4_last_reg;
            out_pixel_reg <= out_pixel_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = out_pixel_reg;
    assign last_of_frame  = out_last_reg;

endmodule

// ----- rtl/gaussian_window_convolution_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian window convolution unit
// Valid-region 3x3 or 5x5 convolution of an 8-bit grey raster stream.
// ----------------------------------------------------------------------------
//  Channel   Handshake               Payload
//  input     in_valid / in_ready     pixel, start_of_frame
//  output    out_valid / out_ready   filtered_pixel, last_of_frame
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  One pixel is accepted per clock unless the pipeline is stalled; a result
//  is offered once its pixel has passed the line store read, the window load
//  and three arithmetic stages.
//  Each stage holds its word when the next one is full, so bubbles let new
//  pixels in while a result waits. The line store needs no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_window_convolution_unit #(
    parameter int MAX_WIDTH   = gwc_pkg::DEF_MAX_WIDTH,
    parameter int COEFF_WIDTH = gwc_pkg::DEF_COEFF_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  gwc_pkg::pixel_t                   pixel,
    input  logic                              start_of_frame,
    output logic                              out_valid,
    input  logic                              out_ready,
    output gwc_pkg::pixel_t                   filtered_pixel,
    output logic                              last_of_frame,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [gwc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int DIM_W  = gwc_pkg::DIM_W;

    logic [gwc_pkg::RADIUS_W-1:0] kernel_radius_reg;
    logic [DIM_W-1:0]             image_width_reg;
    logic [DIM_W-1:0]             image_height_reg;
    gwc_pkg::coeff_bank_t         coeff_reg;

    logic [ADDR_W-1:0] col_count_reg;
    logic [ADDR_W-1:0] col_count_next;
    logic [DIM_W-1:0]  row_count_reg;
    logic [DIM_W-1:0]  row_count_next;

    logic [ADDR_W-1:0] width_m1;
    logic [DIM_W-1:0]  height_m1;
    logic [ADDR_W-1:0] col_raw;
    logic [ADDR_W-1:0] col;
    logic [DIM_W-1:0]  row_raw;
    logic [DIM_W-1:0]  row;
    logic              narrow;
    logic [2:0]        two_r;
    logic              produce;
    logic              is_last;
    logic              accept;

    logic                       s1_valid_reg;
    gwc_pkg::pixel_t            s1_pixel_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic                       s1_produce_reg;
    logic                       s1_last_reg;
    logic                       s1_narrow_reg;
    logic                       s1_adv;
    logic                       fwd_hit_reg;
    logic [gwc_pkg::LINE_W-1:0] fwd_word_reg;

    logic [gwc_pkg::LINE_W-1:0] rd_data;
    logic [gwc_pkg::LINE_W-1:0] line_word;
    logic [gwc_pkg::LINE_W-1:0] wr_data;

    gwc_pkg::window_t  window;
    gwc_pkg::mac_req_t mac_req;
    logic              mac_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_radius_reg <= gwc_pkg::RESET_RADIUS;
            image_width_reg   <= gwc_pkg::RESET_WIDTH;
            image_height_reg  <= gwc_pkg::RESET_HEIGHT;
            coeff_reg         <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (gwc_pkg::cfg_reg_t'(cfg_index))
                gwc_pkg::REG_KERNEL_RADIUS: kernel_radius_reg <= cfg_data[gwc_pkg::RADIUS_W-1:0];
                gwc_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[DIM_W-1:0];
                gwc_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[DIM_W-1:0];
                gwc_pkg::REG_COEFF_COLUMN0: coeff_reg[0]      <= cfg_data;
                gwc_pkg::REG_COEFF_COLUMN1: coeff_reg[1]      <= cfg_data;
                gwc_pkg::REG_COEFF_COLUMN2: coeff_reg[2]      <= cfg_data;
                gwc_pkg::REG_COEFF_COLUMN3: coeff_reg[3]      <= cfg_data;
                gwc_pkg::REG_COEFF_COLUMN4: coeff_reg[4]      <= cfg_data;
            endcase
        end
    end

    // Position of the incoming pixel, clamped to the current frame size.
    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_m1 = '0;
        end
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
        begin
            width_m1 = ADDR_W'(MAX_WIDTH - 1);
        end
        else
        begin
            width_m1 = ADDR_W'(32'(image_width_reg) - 32'd1);
        end
        height_m1 = (image_height_reg == '0) ? '0 : image_height_reg - DIM_W'(1);

        col_raw = start_of_frame ? '0 : col_count_reg;
        row_raw = start_of_frame ? '0 : row_count_reg;
        col     = (col_raw > width_m1) ? width_m1 : col_raw;
        row     = (row_raw > height_m1) ? height_m1 : row_raw;

        narrow  = kernel_radius_reg <= gwc_pkg::RADIUS_W'(1);
        two_r   = narrow ? 3'd2 : 3'd4;
        produce = (32'(col) >= 32'(two_r)) && (32'(row) >= 32'(two_r));
        is_last = (col == width_m1) && (row == height_m1);

        if (col == width_m1)
        begin
            col_count_next = '0;
            row_count_next = (row == height_m1) ? '0 : row + DIM_W'(1);
        end
        else
        begin
            col_count_next = col + ADDR_W'(1);
            row_count_next = row;
        end
    end

    assign in_ready = !s1_valid_reg || mac_ready;
    assign accept   = in_valid && in_ready;
    assign s1_adv   = s1_valid_reg && mac_ready;

    assign line_word = fwd_hit_reg ? fwd_word_reg : rd_data;
    assign wr_data   = {s1_pixel_reg, line_word[gwc_pkg::LINE_W-1:gwc_pkg::PIXEL_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                col_count_reg <= col_count_next;
                row_count_reg <= row_count_next;
            end
        end
    end

    // The write of the item leaving the first stage lands on the same edge
    // as the read of the next one, so a matching column is forwarded.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pixel;
            s1_addr_reg    <= col;
            s1_produce_reg <= produce;
            s1_last_reg    <= is_last;
            s1_narrow_reg  <= narrow;
            fwd_hit_reg    <= s1_adv && (s1_addr_reg == col);
            fwd_word_reg   <= wr_data;
        end
    end

    gwc_line_store #(
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col),
        .rd_data (rd_data),
        .wr_en   (s1_adv),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    gwc_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift_en  (s1_adv),
        .line_word (line_word),
        .pixel     (s1_pixel_reg),
        .window    (window)
    );

    assign mac_req.valid         = s1_valid_reg && s1_produce_reg;
    assign mac_req.last_of_frame = s1_last_reg;
    assign mac_req.narrow        = s1_narrow_reg;

    gwc_mac_pipe #(
        .COEFF_WIDTH (COEFF_WIDTH)
    ) u_mac_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (mac_req),
        .req_ready      (mac_ready),
        .window         (window),
        .coeff          (coeff_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_pixel (filtered_pixel),
        .last_of_frame  (last_of_frame)
    );

endmodule

// ----- rtl/gwc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convolution unit checker
// Port-level assertions on reset, stalls and back-pressure of the unit.
// ----------------------------------------------------------------------------
module gwc_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  gwc_pkg::pixel_t                   pixel,
    input  logic                              start_of_frame,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  gwc_pkg::pixel_t                   filtered_pixel,
    input  logic                              last_of_frame,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);

    // A stalled result keeps its word.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(filtered_pixel)
        && $stable(last_of_frame))
        else $error("output word changed while stalled");

    // No result is offered as reset is released.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid after reset");

    // Input back-pressure only arises from a full pipeline behind a stalled result.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a stalled result");

    // A stalled input word keeps its payload.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(pixel) && $stable(start_of_frame))
        else $error("input word changed while stalled");

    // Register writes are never refused.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("register write refused");

endmodule

bind gaussian_window_convolution_unit gwc_checker u_gwc_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Convolution unit testbench
// Streams raster frames through the 3x3/5x5 convolution unit under many
// register settings and checks every filtered word against a cycle-free
// predictor of the valid-region convolution, in order and field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 9;
    localparam int DRAIN_CYCLES = 12;
    localparam int TIMEOUT_NS   = 2_000_000;
    localparam int RANDOM_ITEMS = 480;
    localparam int KERNEL_MAX   = gwc_pkg::KERNEL_MAX;
    localparam int NUM_LINES    = gwc_pkg::NUM_LINES;
    localparam int PIXEL_W      = gwc_pkg::PIXEL_W;
    localparam int CFG_DATA_W   = gwc_pkg::CFG_DATA_W;
    localparam int RADIUS_W     = gwc_pkg::RADIUS_W;
    localparam int DIM_W        = gwc_pkg::DIM_W;
    localparam int MAX_W        = gwc_pkg::DEF_MAX_WIDTH;
    localparam int COEFF_W      = gwc_pkg::DEF_COEFF_WIDTH;
    localparam int FRAC_BITS    = COEFF_W - 1;
    localparam int CENTRE       = KERNEL_MAX / 2;

    typedef gwc_pkg::pixel_t   pixel_t;
    typedef gwc_pkg::cfg_reg_t cfg_reg_t;

    typedef enum {
        KERNEL_ZERO,
        KERNEL_SMOOTH,
        KERNEL_SIGNED,
        KERNEL_RANDOM,
        KERNEL_POS_MAX,
        KERNEL_NEG_MAX
    } kernel_kind_t;

    typedef enum {
        PATTERN_RANDOM,
        PATTERN_EXTREME,
        PATTERN_ALTERNATE
    } pixel_pattern_t;

    typedef struct packed {
        pixel_t value;
        logic   sof;
    } raster_word_t;

    typedef struct packed {
        pixel_t value;
        logic   last;
    } conv_result_t;

    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    pixel_t                pixel          = '0;
    logic                  start_of_frame = 1'b0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    pixel_t                filtered_pixel;
    logic                  last_of_frame;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    cfg_reg_t              cfg_index      = gwc_pkg::REG_KERNEL_RADIUS;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    raster_word_t raster_queue[$];
    conv_result_t conv_expected[$];
    int           queued_count   = 0;
    int           taken_count    = 0;
    int           error_count    = 0;
    int           send_gap       = 0;
    int           stall_gap      = 0;
    logic         pixel_handshake = 1'b0;
    logic         cfg_handshake   = 1'b0;
    bit           idle_enable     = 1'b1;

    logic [RADIUS_W-1:0]   cur_radius = gwc_pkg::RESET_RADIUS;
    logic [DIM_W-1:0]      cur_width  = gwc_pkg::RESET_WIDTH;
    logic [DIM_W-1:0]      cur_height = gwc_pkg::RESET_HEIGHT;
    logic [CFG_DATA_W-1:0] cur_coeff [KERNEL_MAX] = '{default: '0};
    bit [PIXEL_W-1:0]      row_history [NUM_LINES][MAX_W];
    bit [PIXEL_W-1:0]      pix_window [KERNEL_MAX][KERNEL_MAX];
    int                    col_pos = 0;
    int                    row_pos = 0;

    gaussian_window_convolution_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pixel          (pixel),
        .start_of_frame (start_of_frame),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .filtered_pixel (filtered_pixel),
        .last_of_frame  (last_of_frame),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    function automatic void predict_pixel(input pixel_t px, input logic sof);
        int w, h, r, c, row, acc, tap, scaled;
        pixel_t column [KERNEL_MAX];
        conv_result_t res;
        w = (cur_width > MAX_W) ? MAX_W : ((cur_width == 0) ? 1 : int'(cur_width));
        h = (cur_height == 0) ? 1 : int'(cur_height);
        r = (cur_radius == 0) ? 1 : ((cur_radius > CENTRE) ? CENTRE : int'(cur_radius));
        if (sof)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c   = (col_pos >= w) ? w - 1 : col_pos;
        row = (row_pos >= h) ? h - 1 : row_pos;
        for (int i = 0; i < NUM_LINES; i++)
            column[i] = row_history[i][c];
        column[NUM_LINES] = px;
        for (int i = 0; i < NUM_LINES - 1; i++)
            row_history[i][c] = row_history[i + 1][c];
        row_history[NUM_LINES - 1][c] = px;
        for (int i = 0; i < KERNEL_MAX; i++)
        begin
            for (int j = 0; j < KERNEL_MAX - 1; j++)
                pix_window[i][j] = pix_window[i][j + 1];
            pix_window[i][KERNEL_MAX - 1] = column[i];
        end
        if (w >= 2 * r + 1 && h >= 2 * r + 1 && c >= 2 * r && row >= 2 * r)
        begin
            acc = 0;
            for (int dx = -r; dx <= r; dx++)
            begin
                for (int dy = -r; dy <= r; dy++)
                begin
                    tap = $signed(cur_coeff[CENTRE + dx][(CENTRE + dy) * COEFF_W +: COEFF_W]);
                    acc += tap * int'(pix_window[KERNEL_MAX - 1 - r + dy][KERNEL_MAX - 1 - r + dx]);
                end
            end
            if (acc <= 0)
                scaled = 0;
            else
                scaled = acc >> FRAC_BITS;
            res.value = (scaled > 255) ? 8'hFF : pixel_t'(scaled);
            res.last  = (c == w - 1 && row == h - 1);
            conv_expected = {conv_expected, res};
        end
        if (c >= w - 1)
        begin
            col_pos = 0;
            row_pos = (row >= h - 1) ? 0 : row + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = row;
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] kernel_column(input kernel_kind_t kind);
        logic [CFG_DATA_W-1:0] col;
        logic [COEFF_W-1:0]    tap;
        col = '0;
        for (int k = 0; k < KERNEL_MAX; k++)
        begin
            case (kind)
                KERNEL_ZERO:    tap = '0;
                KERNEL_SMOOTH:  tap = COEFF_W'($urandom_range(0, 160));
                KERNEL_SIGNED:  tap = COEFF_W'($urandom_range(0, 400) - 200);
                KERNEL_RANDOM:  tap = COEFF_W'($urandom);
                KERNEL_POS_MAX: tap = {1'b0, {(COEFF_W - 1){1'b1}}};
                default:        tap = {1'b1, {(COEFF_W - 1){1'b0}}};
            endcase
            col[k * COEFF_W +: COEFF_W] = tap;
        end
        return col;
    endfunction

    task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(negedge clk);
        while (!cfg_handshake);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle_block();
        while (taken_count != queued_count || conv_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int radius, input int width, input int height,
                             input kernel_kind_t kind, input pixel_pattern_t pattern,
                             input int count, input bit lead_sof, input int noise_rate,
                             output bit noisy);
        raster_word_t word;
        settle_block();
        write_register(gwc_pkg::REG_KERNEL_RADIUS, CFG_DATA_W'(radius));
        write_register(gwc_pkg::REG_IMAGE_WIDTH, CFG_DATA_W'(width));
        write_register(gwc_pkg::REG_IMAGE_HEIGHT, CFG_DATA_W'(height));
        for (int c = 0; c < KERNEL_MAX; c++)
            write_register(cfg_reg_t'(gwc_pkg::REG_COEFF_COLUMN0 + c), kernel_column(kind));
        @(posedge clk);
        noisy = 1'b0;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                word.sof = lead_sof;
            else
                word.sof = (noise_rate != 0) && ($urandom_range(1, noise_rate) == 1);
            noisy |= (i != 0) && word.sof;
            case (pattern)
                PATTERN_EXTREME:   word.value = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                PATTERN_ALTERNATE: word.value = (i % 2 == 1) ? 8'hFF : 8'h00;
                default:           word.value = pixel_t'($urandom_range(0, 255));
            endcase
            raster_queue = {raster_queue, word};
            queued_count++;
        end
    endtask

    always @(negedge clk)
    begin : pixel_driver
        raster_word_t word;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || pixel_handshake)
        begin
            if (send_gap != 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (idle_enable && raster_queue.size() != 0 && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                send_gap <= $urandom_range(0, 6);
            end
            else if (raster_queue.size() != 0)
            begin
                word = raster_queue.pop_front();
                in_valid       <= 1'b1;
                pixel          <= word.value;
                start_of_frame <= word.sof;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : ready_driver
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_gap <= 0;
        end
        else if (stall_gap != 0)
        begin
            out_ready <= 1'b0;
            stall_gap <= stall_gap - 1;
        end
        else if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_gap <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : monitor
        conv_result_t want;
        if (!rst_n)
        begin
            pixel_handshake <= 1'b0;
            cfg_handshake   <= 1'b0;
        end
        else
        begin
            pixel_handshake <= in_valid && in_ready;
            cfg_handshake   <= cfg_valid && cfg_ready;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gwc_pkg::REG_KERNEL_RADIUS: cur_radius = cfg_data[RADIUS_W-1:0];
                    gwc_pkg::REG_IMAGE_WIDTH:   cur_width  = cfg_data[DIM_W-1:0];
                    gwc_pkg::REG_IMAGE_HEIGHT:  cur_height = cfg_data[DIM_W-1:0];
                    default:
                        cur_coeff[int'(cfg_index) - int'(gwc_pkg::REG_COEFF_COLUMN0)] = cfg_data;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_pixel(pixel, start_of_frame);
                taken_count <= taken_count + 1;
            end
            if (out_valid && out_ready)
            begin
                if (conv_expected.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected word, expected none, actual pixel %0d last %0b",
                             $time, filtered_pixel, last_of_frame);
                end
                else
                begin
                    want = conv_expected.pop_front();
                    if (filtered_pixel !== want.value)
                    begin
                        error_count++;
                        $display("%0t: filtered_pixel expected %0d actual %0d",
                                 $time, want.value, filtered_pixel);
                    end
                    if (last_of_frame !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last_of_frame expected %0b actual %0b",
                                 $time, want.last, last_of_frame);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int             width, height, radius, eff_w, eff_h, count, prev_w, noise;
        int             random_items, drain;
        bit             lead_sof, may_continue, noisy;
        kernel_kind_t   kind;
        pixel_pattern_t pattern;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_phase(3, 5, 5, KERNEL_POS_MAX, PATTERN_ALTERNATE, 25, 1'b1, 0, noisy);
        run_phase(2, 0, 0, KERNEL_RANDOM, PATTERN_RANDOM, 6, 1'b1, 0, noisy);
        run_phase(1, 5, 4095, KERNEL_SIGNED, PATTERN_RANDOM, 45, 1'b1, 0, noisy);
        run_phase(0, 4095, 3, KERNEL_SMOOTH, PATTERN_RANDOM, 300, 1'b1, 0, noisy);

        may_continue = 1'b0;
        prev_w       = MAX_W;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            radius = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0:       width = $urandom_range(0, 4);
                1:       width = $urandom_range(13, 40);
                default: width = $urandom_range(5, 12);
            endcase
            case ($urandom_range(0, 9))
                0:       height = $urandom_range(0, 4);
                1:       height = 4095;
                default: height = $urandom_range(5, 10);
            endcase
            eff_w = (width == 0) ? 1 : width;
            eff_h = (height == 0) ? 1 : height;
            if (eff_h > 16)
                count = eff_w * $urandom_range(6, 10);
            else if (eff_w * eff_h > 200)
                count = eff_w * eff_h;
            else
                count = eff_w * eff_h * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0)
                count += $urandom_range(1, 2 * eff_w);
            // A frame may carry on without a new start only where the line store
            // already holds whole rows for every column of the narrower image.
            lead_sof = !(may_continue && eff_w <= prev_w && $urandom_range(0, 1) == 1);
            noise    = ($urandom_range(0, 3) == 0) ? 30 : 0;
            kind     = kernel_kind_t'($urandom_range(0, 5));
            pattern  = ($urandom_range(0, 4) == 0) ? PATTERN_EXTREME : PATTERN_RANDOM;
            idle_enable = (RANDOM_ITEMS - random_items > 150) && ($urandom_range(0, 4) != 0);
            run_phase(radius, width, height, kind, pattern, count, lead_sof, noise, noisy);
            may_continue = !noisy && count >= 5 * eff_w;
            prev_w       = eff_w;
            random_items += count;
        end

        drain = 0;
        while ((taken_count != queued_count || conv_expected.size() != 0) && drain < 100_000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (conv_expected.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, conv_expected.size());
        if (error_count == 0 && conv_expected.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/gwc_pkg.sv
rtl/gwc_line_store.sv
rtl/gwc_window.sv
rtl/gwc_mac_pipe.sv
rtl/gaussian_window_convolution_unit.sv
rtl/gwc_checker.sv
sim/tb_top.sv
